### rtl/core/mplg_pkg.sv
`default_nettype none
package mplg_pkg;

    // Field widths
    localparam int ADDR_W  = 64;
    localparam int PORT_W  = 16;
    localparam int LEN_W   = 16;
    localparam int CNT_W   = 32;
    localparam int BYTES_W = 64;
    localparam int THR_W   = 16;
    localparam int INIT_W  = 10;
    localparam int SEED_W  = 15;
    localparam int MOD_W   = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Generator constants
    localparam int LCG_W        = 31;
    localparam logic [LCG_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [LCG_W-1:0] LCG_INC = 31'd12345;
    localparam int LCG_SHIFT    = 16;
    localparam int DRAW_MOD     = 1000;
    localparam int MOD_STEPS    = 6;
    localparam logic [SEED_W-1:0] SEED_START = 15'd42;

    // Control ports
    localparam logic [PORT_W-1:0] PORT_RETUNE  = 16'd3333;
    localparam logic [PORT_W-1:0] PORT_RESTART = 16'd3334;

    // Threshold tuning
    localparam logic [THR_W-1:0] DROP_WRAP  = 16'd500;
    localparam logic [THR_W-1:0] DROP_STEP  = 16'd20;
    localparam logic [THR_W-1:0] KEEP_STEP  = 16'd10;
    localparam logic [THR_W-1:0] KEEP_FLOOR = 16'd900;
    localparam logic [LEN_W-1:0] ETH_HDR_LEN = 16'd14;

    localparam logic [INIT_W-1:0] INIT_KEEP_RESET = 10'd990;
    localparam logic [INIT_W-1:0] INIT_DROP_RESET = 10'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_HIGH  = 3'd0,
        CFG_ONE_LOW   = 3'd1,
        CFG_TWO_HIGH  = 3'd2,
        CFG_TWO_LOW   = 3'd3,
        CFG_INIT_KEEP = 3'd4,
        CFG_INIT_DROP = 3'd5
    } cfg_index_t;

    typedef enum logic {
        LOSS_PASS = 1'b0,
        LOSS_DROP = 1'b1
    } loss_state_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_addr_high;
        logic [ADDR_W-1:0] dest_addr_low;
        logic [PORT_W-1:0] udp_source_port;
        logic [PORT_W-1:0] udp_dest_port;
        logic [LEN_W-1:0]  frame_length;
    } pkt_t;

    typedef struct packed {
        logic               drop;
        logic [CNT_W-1:0]   packets_counted;
        logic [BYTES_W-1:0] bytes_counted;
    } res_t;

    typedef struct packed {
        logic [ADDR_W-1:0] one_high;
        logic [ADDR_W-1:0] one_low;
        logic [ADDR_W-1:0] two_high;
        logic [ADDR_W-1:0] two_low;
        logic [INIT_W-1:0] init_keep;
        logic [INIT_W-1:0] init_drop;
    } mplg_cfg_t;

endpackage
`default_nettype wire

### rtl/core/mplg_cfg_regs.sv
`default_nettype none
module mplg_cfg_regs
    import mplg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output mplg_cfg_t                  cfg
);

    mplg_cfg_t cfg_reg;
    mplg_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register write; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ONE_HIGH:  cfg_next.one_high  = cfg_data;
                CFG_ONE_LOW:   cfg_next.one_low   = cfg_data;
                CFG_TWO_HIGH:  cfg_next.two_high  = cfg_data;
                CFG_TWO_LOW:   cfg_next.two_low   = cfg_data;
                CFG_INIT_KEEP: cfg_next.init_keep = cfg_data[INIT_W-1:0];
                CFG_INIT_DROP: cfg_next.init_drop = cfg_data[INIT_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.one_high  <= '0;
            cfg_reg.one_low   <= '0;
            cfg_reg.two_high  <= '0;
            cfg_reg.two_low   <= '0;
            cfg_reg.init_keep <= INIT_KEEP_RESET;
            cfg_reg.init_drop <= INIT_DROP_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/mplg_lcg.sv
`default_nettype none
module mplg_lcg
    import mplg_pkg::*;
(
    input  wire logic [SEED_W-1:0] seed,
    output logic      [SEED_W-1:0] draw,
    output logic      [MOD_W-1:0]  draw_mod
);

    logic [LCG_W-1:0]  prod;
    logic [LCG_W-1:0]  sum;
    logic [SEED_W-1:0] rem;

    // Only the low 31 bits of the product reach the drawn bits
    assign prod = LCG_W'(seed) * LCG_MUL;
    assign sum  = prod + LCG_INC;
    assign draw = sum[LCG_SHIFT +: SEED_W];

    // Reduce the draw modulo 1000 by restoring subtraction, largest multiple first
    always_comb
    begin
        rem = draw;
        for (int i = MOD_STEPS - 1; i >= 0; i--)
        begin
            if (rem >= SEED_W'(DRAW_MOD << i))
            begin
                rem = rem - SEED_W'(DRAW_MOD << i);
            end
        end
        draw_mod = rem[MOD_W-1:0];
    end

endmodule
`default_nettype wire

### rtl/core/mplg_chain.sv
`default_nettype none
module mplg_chain
    import mplg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      fire,
    input  wire pkt_t      item,
    input  wire mplg_cfg_t cfg,
    output res_t           result
);

    logic [THR_W-1:0]   keep_reg,  keep_next;
    logic [THR_W-1:0]   drop_reg,  drop_next;
    loss_state_t        loss_reg,  loss_next;
    logic [SEED_W-1:0]  seed_reg,  seed_next;
    logic [CNT_W-1:0]   cnt_reg,   cnt_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;

    logic               watched;
    logic               load;
    logic               retune;
    logic               restart;
    logic [THR_W-1:0]   keep_eff;
    logic [THR_W-1:0]   drop_eff;
    logic [SEED_W-1:0]  seed_eff;
    logic [SEED_W-1:0]  lcg_seed;
    logic [BYTES_W-1:0] bytes_base;
    logic [LEN_W-1:0]   body_len;
    logic [BYTES_W-1:0] bytes_sum;
    logic [CNT_W-1:0]   cnt_sum;
    logic [THR_W-1:0]   keep_tuned;
    logic [THR_W-1:0]   drop_tuned;
    logic [SEED_W-1:0]  draw;
    logic [MOD_W-1:0]   draw_mod;
    logic               chain_drop;
    loss_state_t        chain_state;

    // Match the destination against both watched addresses
    assign watched = (item.dest_addr_high == cfg.one_high && item.dest_addr_low == cfg.one_low)
                  || (item.dest_addr_high == cfg.two_high && item.dest_addr_low == cfg.two_low);

    // Start the model on a watched packet while the keep threshold is still zero
    assign load       = (keep_reg == '0);
    assign keep_eff   = load ? THR_W'(cfg.init_keep) : keep_reg;
    assign drop_eff   = load ? THR_W'(cfg.init_drop) : drop_reg;
    assign seed_eff   = load ? SEED_START : seed_reg;
    assign bytes_base = load ? '0 : bytes_reg;

    // Grow the counters; a runt frame adds no bytes
    assign body_len  = (item.frame_length >= ETH_HDR_LEN) ? item.frame_length - ETH_HDR_LEN
                                                          : '0;
    assign bytes_sum = bytes_base + BYTES_W'(body_len);
    assign cnt_sum   = cnt_reg + CNT_W'(1);

    // Decode control ports
    assign retune  = (item.udp_source_port == PORT_RETUNE)
                  || (item.udp_dest_port == PORT_RETUNE);
    assign restart = !retune && ((item.udp_source_port == PORT_RESTART)
                  || (item.udp_dest_port == PORT_RESTART));

    // Retune thresholds, then clamp keep at its floor
    always_comb
    begin
        if (drop_eff >= DROP_WRAP)
        begin
            drop_tuned = '0;
            keep_tuned = keep_eff - KEEP_STEP;
        end
        else
        begin
            drop_tuned = drop_eff + DROP_STEP;
            keep_tuned = keep_eff;
        end
        if (keep_tuned < KEEP_FLOOR)
        begin
            keep_tuned = KEEP_FLOOR;
        end
    end

    // Draw from the generator
    assign lcg_seed = restart ? '0 : seed_eff;

    mplg_lcg u_lcg (
        .seed     (lcg_seed),
        .draw     (draw),
        .draw_mod (draw_mod)
    );

    // Step the pass/drop chain
    always_comb
    begin
        case (loss_reg)
            LOSS_PASS:
            begin
                if (THR_W'(draw_mod) < keep_eff)
                begin
                    chain_drop  = 1'b0;
                    chain_state = LOSS_PASS;
                end
                else
                begin
                    chain_drop  = 1'b1;
                    chain_state = LOSS_DROP;
                end
            end
            LOSS_DROP:
            begin
                if (THR_W'(draw_mod) >= drop_eff)
                begin
                    chain_drop  = 1'b0;
                    chain_state = LOSS_PASS;
                end
                else
                begin
                    chain_drop  = 1'b1;
                    chain_state = LOSS_DROP;
                end
            end
            default:
            begin
                chain_drop  = 1'b0;
                chain_state = LOSS_PASS;
            end
        endcase
    end

    // Select the result and the next state
    always_comb
    begin
        keep_next  = keep_reg;
        drop_next  = drop_reg;
        loss_next  = loss_reg;
        seed_next  = seed_reg;
        cnt_next   = cnt_reg;
        bytes_next = bytes_reg;
        result.drop            = 1'b0;
        result.packets_counted = cnt_reg;
        result.bytes_counted   = bytes_reg;
        if (watched)
        begin
            if (retune)
            begin
                keep_next  = keep_tuned;
                drop_next  = drop_tuned;
                seed_next  = SEED_START;
                cnt_next   = '0;
                bytes_next = '0;
                result.drop = 1'b1;
            end
            else
            begin
                keep_next  = keep_eff;
                drop_next  = drop_eff;
                loss_next  = chain_state;
                seed_next  = draw;
                cnt_next   = restart ? '0 : cnt_sum;
                bytes_next = restart ? '0 : bytes_sum;
                result.drop = chain_drop;
            end
            result.packets_counted = cnt_next;
            result.bytes_counted   = bytes_next;
        end
    end

    // Advance the model state on each processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_reg  <= '0;
            drop_reg  <= '0;
            loss_reg  <= LOSS_PASS;
            seed_reg  <= '0;
            cnt_reg   <= '0;
            bytes_reg <= '0;
        end
        else if (fire)
        begin
            keep_reg  <= keep_next;
            drop_reg  <= drop_next;
            loss_reg  <= loss_next;
            seed_reg  <= seed_next;
            cnt_reg   <= cnt_next;
            bytes_reg <= bytes_next;
        end
    end

endmodule
`default_nettype wire

### rtl/core/markov_packet_loss_generator_unit.sv
`default_nettype none
// Two-state packet loss generator. Each packet descriptor transfer yields one
// result: drop flag plus the packet and payload byte totals. Packets to either
// watched IPv6 destination advance a pass/drop Markov chain driven by a
// 15-bit LCG draw taken modulo 1000; UDP port 3333 retunes the thresholds and
// drops, port 3334 restarts the counters and seed. The block takes one packet
// per cycle while the result side is not stalled; a result passes through an
// input register and a result register. The per-packet state loop (LCG
// multiply, modulo reduction, threshold compare) is combinational between
// the state registers, which sets that rate. Stall on the result side holds
// the pipeline once the input register is also full. Configuration writes
// are taken in any cycle and belong in idle periods.
module markov_packet_loss_generator_unit
    import mplg_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pkt_valid,
    output logic                       pkt_stall,
    input  wire pkt_t                  pkt,
    output logic                       res_valid,
    input  wire logic                  res_stall,
    output res_t                       res,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    mplg_cfg_t cfg;
    pkt_t      pkt_reg;
    logic      pkt_valid_reg;
    res_t      res_reg;
    logic      res_valid_reg;
    res_t      step_res;
    logic      advance;
    logic      fire;

    mplg_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the pipeline whenever the result register is free or being taken
    assign advance   = !(res_valid_reg && res_stall);
    assign fire      = pkt_valid_reg && advance;
    assign pkt_stall = pkt_valid_reg && !advance;

    mplg_chain u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (pkt_reg),
        .cfg    (cfg),
        .result (step_res)
    );

    // Hold the input stage; load it whenever it is empty or moving on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_valid_reg <= 1'b0;
        end
        else if (!pkt_stall)
        begin
            pkt_valid_reg <= pkt_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pkt_valid && !pkt_stall)
        begin
            pkt_reg <= pkt;
        end
    end

    // Hold the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= pkt_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= step_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
`default_nettype wire

### rtl/core/mplg_checker.sv
`default_nettype none
module mplg_checker
    import mplg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic pkt_valid,
    input  wire logic pkt_stall,
    input  wire logic res_valid,
    input  wire logic res_stall,
    input  wire res_t res
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // Input backpressure only comes from a backed-up result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_stall |-> res_valid && res_stall)
        else $error("input stalled without result backpressure");

    // A transfer in shows up as a valid result when the result side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (pkt_valid && !pkt_stall) ##1 !res_stall |=> res_valid)
        else $error("result missing after transfer in");

endmodule

bind markov_packet_loss_generator_unit mplg_checker u_mplg_checker (.*);
`default_nettype wire

### test/markov_packet_loss_generator_unit_test.sv
`timescale 1ns / 1ps

module markov_packet_loss_generator_unit_test;
    import mplg_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 256;
    localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  pkt_valid = 1'b0;
    logic                  pkt_stall;
    pkt_t                  pkt = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    markov_packet_loss_generator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Register mirror
    logic [ADDR_W-1:0] watch_one_high = '0;
    logic [ADDR_W-1:0] watch_one_low  = '0;
    logic [ADDR_W-1:0] watch_two_high = '0;
    logic [ADDR_W-1:0] watch_two_low  = '0;
    logic [INIT_W-1:0] start_keep     = INIT_KEEP_RESET;
    logic [INIT_W-1:0] start_drop     = INIT_DROP_RESET;

    // Loss model state
    logic [THR_W-1:0]   keep_thr    = '0;
    logic [THR_W-1:0]   drop_thr    = '0;
    loss_state_t        chain_state = LOSS_PASS;
    logic [SEED_W-1:0]  seed        = '0;
    logic [CNT_W-1:0]   pkt_total   = '0;
    logic [BYTES_W-1:0] byte_sum    = '0;

    pkt_t pending_packets[$];
    res_t expected_results[$];
    int   packets_queued = 0;
    int   transfers_in   = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    // Advance the loss model by one packet and return the result it yields
    function res_t predict_loss(input pkt_t p);
        res_t               r;
        logic               watched;
        logic [63:0]        lcg;
        logic [SEED_W-1:0]  residue;
        logic [THR_W-1:0]   draw;
        watched = (p.dest_addr_high == watch_one_high && p.dest_addr_low == watch_one_low) ||
                  (p.dest_addr_high == watch_two_high && p.dest_addr_low == watch_two_low);
        r.drop = 1'b0;
        if (watched)
        begin
            // Load thresholds while the model has not started
            if (keep_thr == '0)
            begin
                keep_thr = {6'd0, start_keep};
                drop_thr = {6'd0, start_drop};
                seed     = SEED_START;
                byte_sum = '0;
            end
            if (p.frame_length >= ETH_HDR_LEN)
                byte_sum = byte_sum + {48'd0, p.frame_length - ETH_HDR_LEN};
            pkt_total = pkt_total + 1'b1;
            if (p.udp_source_port == PORT_RETUNE || p.udp_dest_port == PORT_RETUNE)
            begin
                // Retune: drop the packet, restart counters, step thresholds
                byte_sum  = '0;
                pkt_total = '0;
                seed      = SEED_START;
                if (drop_thr >= DROP_WRAP)
                begin
                    drop_thr = '0;
                    keep_thr = keep_thr - KEEP_STEP;
                end
                else
                    drop_thr = drop_thr + DROP_STEP;
                if (keep_thr < KEEP_FLOOR)
                    keep_thr = KEEP_FLOOR;
                r.drop = 1'b1;
            end
            else
            begin
                if (p.udp_source_port == PORT_RESTART || p.udp_dest_port == PORT_RESTART)
                begin
                    byte_sum  = '0;
                    pkt_total = '0;
                    seed      = '0;
                end
                // Draw and step the two-state chain
                lcg     = {49'd0, seed} * {33'd0, LCG_MUL} + {33'd0, LCG_INC};
                seed    = lcg[30:16];
                residue = seed % 15'd1000;
                draw    = {1'b0, residue};
                if (chain_state == LOSS_PASS)
                begin
                    if (draw >= keep_thr)
                    begin
                        chain_state = LOSS_DROP;
                        r.drop = 1'b1;
                    end
                end
                else
                begin
                    if (draw >= drop_thr)
                        chain_state = LOSS_PASS;
                    else
                        r.drop = 1'b1;
                end
            end
        end
        r.packets_counted = pkt_total;
        r.bytes_counted   = byte_sum;
        return r;
    endfunction

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Packet driver: record each transfer, then present the next item or idle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pkt_valid <= 1'b0;
        else
        begin
            if (pkt_valid && !pkt_stall)
            begin
                expected_results.push_back(predict_loss(pkt));
                transfers_in = transfers_in + 1;
            end
            if (!pkt_valid || !pkt_stall)
            begin
                if (pending_packets.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    pkt       <= pending_packets.pop_front();
                    pkt_valid <= 1'b1;
                end
                else
                    pkt_valid <= 1'b0;
            end
        end
    end

    // Result side stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_stall <= 1'b0;
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Result monitor: compare each transfer out with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer: drop %0d packets %0d bytes %0d",
                       res.drop, res.packets_counted, res.bytes_counted);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                if (res.drop !== expected_results[0].drop)
                begin
                    $error("drop: expected %0d actual %0d",
                           expected_results[0].drop, res.drop);
                    mismatch_count = mismatch_count + 1;
                end
                if (res.packets_counted !== expected_results[0].packets_counted)
                begin
                    $error("packets_counted: expected %0d actual %0d",
                           expected_results[0].packets_counted, res.packets_counted);
                    mismatch_count = mismatch_count + 1;
                end
                if (res.bytes_counted !== expected_results[0].bytes_counted)
                begin
                    $error("bytes_counted: expected %0d actual %0d",
                           expected_results[0].bytes_counted, res.bytes_counted);
                    mismatch_count = mismatch_count + 1;
                end
                void'(expected_results.pop_front());
            end
        end
    end

    // Write one register and update the mirror once it is taken
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ONE_HIGH:  watch_one_high = value;
            CFG_ONE_LOW:   watch_one_low  = value;
            CFG_TWO_HIGH:  watch_two_high = value;
            CFG_TWO_LOW:   watch_two_low  = value;
            CFG_INIT_KEEP: start_keep     = value[INIT_W-1:0];
            CFG_INIT_DROP: start_drop     = value[INIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_watch(input logic [ADDR_W-1:0] one_high, input logic [ADDR_W-1:0] one_low,
                             input logic [ADDR_W-1:0] two_high, input logic [ADDR_W-1:0] two_low);
        write_reg(CFG_ONE_HIGH, one_high);
        write_reg(CFG_ONE_LOW, one_low);
        write_reg(CFG_TWO_HIGH, two_high);
        write_reg(CFG_TWO_LOW, two_low);
    endtask

    task automatic queue_packet(input logic [ADDR_W-1:0] dhi, input logic [ADDR_W-1:0] dlo,
                                input logic [PORT_W-1:0] sport, input logic [PORT_W-1:0] dport,
                                input logic [LEN_W-1:0] flen);
        pkt_t p;
        p.dest_addr_high  = dhi;
        p.dest_addr_low   = dlo;
        p.udp_source_port = sport;
        p.udp_dest_port   = dport;
        p.frame_length    = flen;
        pending_packets.push_back(p);
        packets_queued = packets_queued + 1;
    endtask

    // Hold until every queued packet has been taken and answered
    task automatic wait_drained();
        do
            @(posedge clk);
        while (transfers_in != packets_queued || expected_results.size() != 0);
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [PORT_W-1:0] rand_port();
        return PORT_W'($urandom_range(65535));
    endfunction

    // Mostly watched packets with random content, some near misses and noise
    task automatic queue_random_packet();
        logic [ADDR_W-1:0] dhi;
        logic [ADDR_W-1:0] dlo;
        logic [PORT_W-1:0] sport;
        logic [PORT_W-1:0] dport;
        logic [LEN_W-1:0]  flen;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 40)
        begin
            dhi = watch_one_high;
            dlo = watch_one_low;
        end
        else if (pick < 80)
        begin
            dhi = watch_two_high;
            dlo = watch_two_low;
        end
        else if (pick < 90)
        begin
            dhi = rand_addr();
            dlo = rand_addr();
        end
        else if (pick < 95)
        begin
            dhi = watch_one_high;
            dlo = watch_one_low ^ (64'd1 << $urandom_range(63));
        end
        else if (pick < 97)
        begin
            dhi = watch_two_high ^ (64'd1 << $urandom_range(63));
            dlo = watch_two_low;
        end
        else
        begin
            dhi = '0;
            dlo = '0;
        end
        sport = rand_port();
        dport = rand_port();
        pick = $urandom_range(99);
        if (pick < 3)
            sport = PORT_RETUNE;
        else if (pick < 6)
            dport = PORT_RETUNE;
        else if (pick < 9)
            sport = PORT_RESTART;
        else if (pick < 12)
            dport = PORT_RESTART;
        pick = $urandom_range(99);
        if (pick < 5)
            flen = ETH_HDR_LEN;
        else if (pick < 10)
            flen = 16'hFFFF;
        else
            flen = LEN_W'($urandom_range(65535, 14));
        queue_packet(dhi, dlo, sport, dport, flen);
    endtask

    // Stimulus sequence
    initial
    begin
        logic [ADDR_W-1:0] h;
        logic [ADDR_W-1:0] l;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero keep register: thresholds reload on every watched packet;
        // reset addresses are zero, so an all-zero destination is watched
        write_reg(CFG_INIT_KEEP, 64'd0);
        write_reg(CFG_INIT_DROP, 64'd1023);
        queue_packet('0, '0, 16'd1000, 16'd2000, ETH_HDR_LEN);
        queue_packet('0, '0, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_packet('0, '0, PORT_RESTART, 16'd53, 16'd100);
        queue_packet('0, '0, 16'd7, PORT_RESTART, 16'd1514);
        queue_packet(64'd1, '0, 16'd1, 16'd2, 16'd64);
        queue_packet('0, 64'h8000_0000_0000_0000, 16'd1, 16'd2, 16'd64);
        queue_packet('0, '0, 16'd9, 16'd9, 16'd77);
        wait_drained();

        // First real load: low keep threshold so the chain toggles often
        h = rand_addr() & ~64'd1;
        l = rand_addr();
        set_watch(ALL_ONES, ALL_ONES, h, l);
        write_reg(CFG_INIT_KEEP, 64'd700);
        write_reg(CFG_INIT_DROP, 64'd300);
        queue_packet(ALL_ONES, ALL_ONES, rand_port(), rand_port(), 16'd1514);
        repeat (5)
            queue_packet(h, l, rand_port(), rand_port(), LEN_W'($urandom_range(1500, 14)));
        queue_packet(ALL_ONES, ALL_ONES, PORT_RETUNE, 16'd80, 16'd200);
        queue_packet(h, l, 16'd443, PORT_RETUNE, 16'd300);
        queue_packet(ALL_ONES, l, 16'd1, 16'd2, 16'd500);
        queue_packet('0, '0, 16'd1, 16'd2, 16'd500);
        queue_packet(h, l, PORT_RESTART, PORT_RESTART, 16'hFFFF);
        queue_packet(ALL_ONES, ALL_ONES, PORT_RETUNE, PORT_RETUNE, ETH_HDR_LEN);
        queue_packet(h, l, PORT_RETUNE, PORT_RESTART, 16'd90);
        queue_packet(h, l, 16'd0, 16'hFFFF, ETH_HDR_LEN);
        queue_packet(ALL_ONES, ALL_ONES, 16'hFFFF, 16'd0, 16'hFFFF);
        wait_drained();

        // Random phases, each with its own watch setting and idling pattern
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_watch(rand_addr(), rand_addr(), rand_addr(), rand_addr());
                    write_reg(CFG_INIT_KEEP, 64'd1023);
                    write_reg(CFG_INIT_DROP, 64'd0);
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                    set_watch('0, '0, ALL_ONES, ALL_ONES);
                    write_reg(CFG_INIT_KEEP, 64'd990);
                    write_reg(CFG_INIT_DROP, 64'd500);
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                    h = rand_addr();
                    l = rand_addr();
                    set_watch(h, l, h, l);
                    write_reg(CFG_INIT_KEEP, 64'd1000);
                    write_reg(CFG_INIT_DROP, 64'd1000);
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                    set_watch(rand_addr(), rand_addr(), rand_addr(), rand_addr());
                    write_reg(CFG_INIT_KEEP, 64'd512);
                    write_reg(CFG_INIT_DROP, 64'd7);
                end
            endcase
            repeat (PHASE_ITEMS)
                queue_random_packet();
            wait_drained();
        end

        // Let any stray result show up before the verdict
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
